/* sv/oass_pkg.sv */
// oass_pkg: types, codes, widths and conversion constants for the obstacle
// avoid sweep sequencer; shared by the core and its checker
// no dependencies
`default_nettype none

package oass_pkg;

    // echo counter width and the stream widths that follow from it
    localparam int COUNT_WIDTH = 16;
    localparam int S_TDATA_W   = ((COUNT_WIDTH + 7) / 8) * 8;

    // result fields
    localparam int CMD_W   = 3;
    localparam int PULSE_W = 16;
    localparam int DIST_W  = 10;
    localparam int MODE_W  = 3;

    localparam int OUT_CMD_LSB   = 0;
    localparam int OUT_PULSE_LSB = OUT_CMD_LSB + CMD_W;
    localparam int OUT_ON_LSB    = OUT_PULSE_LSB + PULSE_W;
    localparam int OUT_DIST_LSB  = OUT_ON_LSB + 1;
    localparam int OUT_MODE_LSB  = OUT_DIST_LSB + DIST_W;
    localparam int OUT_USED_W    = OUT_MODE_LSB + MODE_W;
    localparam int M_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int STOP_W     = 10;
    localparam int TICKS_W    = 16;
    localparam int STEP_W     = 12;

    localparam logic [STOP_W-1:0]  STOP_DIST_RST    = 10'd12;
    localparam logic [TICKS_W-1:0] BACKUP_TICKS_RST = 16'd20;
    localparam logic [TICKS_W-1:0] TURN_TICKS_RST   = 16'd50;
    localparam logic [STEP_W-1:0]  SWEEP_STEP_RST   = 12'd25;
    localparam logic [PULSE_W-1:0] SWEEP_START_RST  = 16'd4500;
    localparam logic [PULSE_W-1:0] RIGHT_LIMIT_RST  = 16'd1500;
    localparam logic [PULSE_W-1:0] LEFT_LIMIT_RST   = 16'd7700;
    localparam logic [PULSE_W-1:0] CENTER_PULSE_RST = 16'd4499;

    // distance codes
    localparam logic [DIST_W-1:0] NO_ECHO_CM = 10'd646;
    localparam logic [DIST_W-1:0] DIST_MAX   = 10'd1023;

    // floor(2c/3): x = 2c, multiply by ceil(2^k/3) and shift by k
    localparam int X_W         = COUNT_WIDTH + 1;
    localparam int DIV3_SHIFT  = X_W + 1;
    localparam int DIV3_MUL_W  = DIV3_SHIFT - 1;
    localparam longint unsigned DIV3_MUL = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
    localparam int T_W         = COUNT_WIDTH;
    localparam int PROD3_W     = X_W + DIV3_MUL_W;

    // floor(17t/1000): y = 16t + t, multiply by ceil(2^k/1000) and shift by k
    localparam int Y_W         = T_W + 5;
    localparam int DIVK_SHIFT  = Y_W + 10;
    localparam int DIVK_MUL_W  = DIVK_SHIFT - 9;
    localparam longint unsigned DIVK_MUL =
        ((64'd1 << DIVK_SHIFT) + 64'd999) / 64'd1000;
    localparam int D_W         = Y_W - 9;
    localparam int PRODK_W     = Y_W + DIVK_MUL_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_FORWARD  = 3'd0,
        MODE_BACKWARD = 3'd1,
        MODE_RIGHT    = 3'd2,
        MODE_LEFT     = 3'd3,
        MODE_SWEEP_R  = 3'd4,
        MODE_SWEEP_L  = 3'd5
    } mode_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_FWD   = 3'd1,
        CMD_BACK  = 3'd2,
        CMD_RIGHT = 3'd3,
        CMD_LEFT  = 3'd4,
        CMD_STOP  = 3'd5
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STOP_DIST    = 4'd0,
        REG_BACKUP_TICKS = 4'd1,
        REG_TURN_TICKS   = 4'd2,
        REG_SWEEP_STEP   = 4'd3,
        REG_SWEEP_START  = 4'd4,
        REG_RIGHT_LIMIT  = 4'd5,
        REG_LEFT_LIMIT   = 4'd6,
        REG_CENTER_PULSE = 4'd7
    } cfg_reg_t;

endpackage

`default_nettype wire

/* sv/obstacle_avoid_sweep_sequencer_core.sv */
// obstacle_avoid_sweep_sequencer_core: top level, echo to distance conversion
// pipeline and the six-mode avoidance sequencer
// depends on oass_pkg
//
// usage
//   s_* stream: one beat per control tick; s_tdata carries the echo count,
//   s_tuser the echo timeout flag
//   m_* stream: one result beat per tick, in order; m_tdata packs motor
//   command, servo pulse, servo on, distance and mode; m_tuser is distance used
//   cfg_*: register writes, taken on any edge with cfg_wr_en high; indexes 8
//   and up are dropped; write only with no tick in flight (not enforced)
// pipeline and throughput
//   an accepted tick passes the input register, the divide-by-3 multiply and
//   the divide-by-1000 multiply, then the sequencer step into the result
//   register; one tick per cycle sustained while m_tready stays high
// reset
//   rst_n low clears the pipeline, the mode (forward, entry due), the counters
//   and loads the register defaults; the servo pulse reads 4499, servo off
// stall
//   each stage holds while the one after it is full and stalled, so up to four
//   ticks sit in the block before s_tready drops
`default_nettype none

module obstacle_avoid_sweep_sequencer_core
    import oass_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // echo_count
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // echo_timeout
    input  wire logic                  s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // motor_command, servo_pulse, servo_on, distance_cm, mode, zero fill
    output logic [M_TDATA_W-1:0]       m_tdata,
    // distance_used
    output logic                       m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    logic [STOP_W-1:0]  stop_dist_reg;
    logic [TICKS_W-1:0] backup_ticks_reg;
    logic [TICKS_W-1:0] turn_ticks_reg;
    logic [STEP_W-1:0]  sweep_step_reg;
    logic [PULSE_W-1:0] sweep_start_reg;
    logic [PULSE_W-1:0] right_limit_reg;
    logic [PULSE_W-1:0] left_limit_reg;
    logic [PULSE_W-1:0] center_pulse_reg;

    // pipeline
    logic                   in_valid_reg;
    logic [COUNT_WIDTH-1:0] in_count_reg;
    logic                   in_timeout_reg;
    logic                   t_valid_reg;
    logic [T_W-1:0]         t_reg;
    logic                   t_timeout_reg;
    logic                   d_valid_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;
    logic                   out_used_reg;

    logic out_ready, d_ready, t_ready, in_ready, step_en;

    // sequencer state
    mode_t              mode_reg, mode_next;
    logic               entry_reg;
    logic [PULSE_W-1:0] step_count_reg, step_count_next;
    logic [DIST_W-1:0]  right_clear_reg, right_clear_next;
    logic [PULSE_W-1:0] pulse_reg, pulse_next;
    logic               pulse_on_reg, pulse_on_next;

    // conversion datapath
    logic [X_W-1:0]     x_val;
    logic [PROD3_W-1:0] prod3;
    logic [Y_W-1:0]     y_val;
    logic [PRODK_W-1:0] prodk;
    logic [D_W-1:0]     d_val;
    logic [DIST_W-1:0]  dist_val;

    // step datapath
    logic [PULSE_W-1:0] count_base;
    logic [PULSE_W-1:0] count_new;
    logic               exit_hit;
    cmd_t               cmd_val;
    logic               used_val;

    assign out_ready = !out_valid_reg || m_tready;
    assign d_ready   = !d_valid_reg || out_ready;
    assign t_ready   = !t_valid_reg || d_ready;
    assign in_ready  = !in_valid_reg || t_ready;
    assign step_en   = d_valid_reg && out_ready;

    assign s_tready  = in_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_used_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_dist_reg    <= STOP_DIST_RST;
            backup_ticks_reg <= BACKUP_TICKS_RST;
            turn_ticks_reg   <= TURN_TICKS_RST;
            sweep_step_reg   <= SWEEP_STEP_RST;
            sweep_start_reg  <= SWEEP_START_RST;
            right_limit_reg  <= RIGHT_LIMIT_RST;
            left_limit_reg   <= LEFT_LIMIT_RST;
            center_pulse_reg <= CENTER_PULSE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_STOP_DIST:    stop_dist_reg    <= cfg_wdata[STOP_W-1:0];
                REG_BACKUP_TICKS: backup_ticks_reg <= cfg_wdata[TICKS_W-1:0];
                REG_TURN_TICKS:   turn_ticks_reg   <= cfg_wdata[TICKS_W-1:0];
                REG_SWEEP_STEP:   sweep_step_reg   <= cfg_wdata[STEP_W-1:0];
                REG_SWEEP_START:  sweep_start_reg  <= cfg_wdata[PULSE_W-1:0];
                REG_RIGHT_LIMIT:  right_limit_reg  <= cfg_wdata[PULSE_W-1:0];
                REG_LEFT_LIMIT:   left_limit_reg   <= cfg_wdata[PULSE_W-1:0];
                REG_CENTER_PULSE: center_pulse_reg <= cfg_wdata[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- conversion pipeline ----------------

    always_comb
    begin
        x_val = {in_count_reg, 1'b0};
        prod3 = PROD3_W'(x_val) * PROD3_W'(DIV3_MUL);
        y_val = (Y_W'(t_reg) << 4) + Y_W'(t_reg);
        prodk = PRODK_W'(y_val) * PRODK_W'(DIVK_MUL);
        d_val = prodk[DIVK_SHIFT +: D_W];
        if (t_timeout_reg || d_val == '0)
            dist_val = NO_ECHO_CM;
        else if ((D_W + DIST_W)'(d_val) > (D_W + DIST_W)'(DIST_MAX))
            dist_val = DIST_MAX;
        else
            dist_val = DIST_W'(d_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            t_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= s_tvalid;
            if (t_ready)
                t_valid_reg <= in_valid_reg;
            if (d_ready)
                d_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_tvalid)
        begin
            in_count_reg   <= s_tdata[COUNT_WIDTH-1:0];
            in_timeout_reg <= s_tuser;
        end
        if (t_ready && in_valid_reg)
        begin
            t_reg         <= prod3[DIV3_SHIFT +: T_W];
            t_timeout_reg <= in_timeout_reg;
        end
        if (d_ready && t_valid_reg)
            dist_reg <= dist_val;
    end

    // ---------------- sequencer step ----------------

    // shared counter arithmetic and the exit test of the current mode
    always_comb
    begin
        count_base = step_count_reg;
        count_new  = step_count_reg;
        exit_hit   = 1'b0;
        unique case (mode_reg)
            MODE_BACKWARD:
            begin
                count_base = entry_reg ? '0 : step_count_reg;
                count_new  = count_base + PULSE_W'(1);
                exit_hit   = count_new >= backup_ticks_reg;
            end
            MODE_SWEEP_R:
            begin
                count_base = entry_reg ? sweep_start_reg : step_count_reg;
                count_new  = count_base - PULSE_W'(sweep_step_reg);
                exit_hit   = count_new < right_limit_reg;
            end
            MODE_SWEEP_L:
            begin
                count_base = entry_reg ? sweep_start_reg : step_count_reg;
                count_new  = count_base + PULSE_W'(sweep_step_reg);
                exit_hit   = count_new > left_limit_reg;
            end
            MODE_RIGHT, MODE_LEFT:
            begin
                count_base = entry_reg ? '0 : step_count_reg;
                count_new  = count_base + PULSE_W'(1);
                exit_hit   = count_new >= turn_ticks_reg;
            end
            default:
                exit_hit = dist_reg < stop_dist_reg;
        endcase
    end

    // next mode
    always_comb
    begin
        unique case (mode_reg)
            MODE_BACKWARD: mode_next = exit_hit ? MODE_SWEEP_R : MODE_BACKWARD;
            MODE_SWEEP_R:  mode_next = exit_hit ? MODE_SWEEP_L : MODE_SWEEP_R;
            MODE_SWEEP_L:
            begin
                if (!exit_hit)
                    mode_next = MODE_SWEEP_L;
                else if (dist_reg > right_clear_reg)
                    mode_next = MODE_LEFT;
                else
                    mode_next = MODE_RIGHT;
            end
            MODE_RIGHT:    mode_next = exit_hit ? MODE_FORWARD : MODE_RIGHT;
            MODE_LEFT:     mode_next = exit_hit ? MODE_FORWARD : MODE_LEFT;
            default:       mode_next = exit_hit ? MODE_BACKWARD : MODE_FORWARD;
        endcase
    end

    // command, servo and counter updates
    always_comb
    begin
        cmd_val          = CMD_NONE;
        used_val         = 1'b0;
        step_count_next  = count_new;
        right_clear_next = right_clear_reg;
        pulse_next       = pulse_reg;
        pulse_on_next    = pulse_on_reg;
        unique case (mode_reg)
            MODE_BACKWARD:
            begin
                if (exit_hit)
                    cmd_val = CMD_STOP;
                else if (entry_reg)
                    cmd_val = CMD_BACK;
            end
            MODE_SWEEP_R:
            begin
                used_val         = exit_hit;
                pulse_next       = exit_hit ? center_pulse_reg : count_new;
                pulse_on_next    = !exit_hit;
                if (exit_hit)
                    right_clear_next = dist_reg;
            end
            MODE_SWEEP_L:
            begin
                used_val      = exit_hit;
                pulse_next    = exit_hit ? center_pulse_reg : count_new;
                pulse_on_next = !exit_hit;
            end
            MODE_RIGHT:
                cmd_val = entry_reg ? CMD_RIGHT : CMD_NONE;
            MODE_LEFT:
                cmd_val = entry_reg ? CMD_LEFT : CMD_NONE;
            default:
            begin
                cmd_val  = entry_reg ? CMD_FWD : CMD_NONE;
                used_val = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_FORWARD;
            entry_reg       <= 1'b1;
            step_count_reg  <= '0;
            right_clear_reg <= '0;
            pulse_reg       <= CENTER_PULSE_RST;
            pulse_on_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_ready)
                out_valid_reg <= d_valid_reg;
            if (step_en)
            begin
                mode_reg        <= mode_next;
                entry_reg       <= mode_next != mode_reg;
                step_count_reg  <= step_count_next;
                right_clear_reg <= right_clear_next;
                pulse_reg       <= pulse_next;
                pulse_on_reg    <= pulse_on_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_data_reg <= M_TDATA_W'({mode_next, dist_reg, pulse_on_next,
                                        pulse_next, cmd_val});
            out_used_reg <= used_val;
        end
    end

endmodule

`default_nettype wire

/* sv/oass_checker.sv */
// oass_checker: port-level checks on the obstacle avoid sweep sequencer core,
// bound to the top level
// depends on oass_pkg and obstacle_avoid_sweep_sequencer_core
`default_nettype none

module oass_checker
    import oass_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready
);

    logic [CMD_W-1:0]  cmd_f;
    logic [MODE_W-1:0] mode_f;
    logic              on_f;

    assign cmd_f  = m_tdata[OUT_CMD_LSB +: CMD_W];
    assign mode_f = m_tdata[OUT_MODE_LSB +: MODE_W];
    assign on_f   = m_tdata[OUT_ON_LSB];

    // stalled result beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // an empty result register never blocks the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

    // servo runs only while a sweep continues
    a_servo_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && on_f |-> mode_f == MODE_SWEEP_R || mode_f == MODE_SWEEP_L)
        else $error("servo on outside a sweep");

    // stop ends reversing and starts the right sweep
    a_stop_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cmd_f == CMD_STOP |-> mode_f == MODE_SWEEP_R)
        else $error("stop command without entering the right sweep");

    // a right turn command leaves the block turning right or already forward
    a_turn_right: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cmd_f == CMD_RIGHT |-> mode_f == MODE_RIGHT || mode_f == MODE_FORWARD)
        else $error("right command in wrong mode");

endmodule

bind obstacle_avoid_sweep_sequencer_core oass_checker u_oass_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
